FILE: src/rvdec_pkg.sv
// Shared types and encoding constants for the RV32I instruction decoder.
package rvdec_pkg;

	// Major opcodes, bits [6:0] of the instruction word.
	localparam logic [6:0] OPC_LUI    = 7'b0110111;
	localparam logic [6:0] OPC_AUIPC  = 7'b0010111;
	localparam logic [6:0] OPC_JAL    = 7'b1101111;
	localparam logic [6:0] OPC_BRANCH = 7'b1100011;
	localparam logic [6:0] OPC_JALR   = 7'b1100111;
	localparam logic [6:0] OPC_LOAD   = 7'b0000011;
	localparam logic [6:0] OPC_OP_IMM = 7'b0010011;
	localparam logic [6:0] OPC_OP     = 7'b0110011;
	localparam logic [6:0] OPC_STORE  = 7'b0100011;

	// Format classes.
	localparam logic [2:0] FMT_U = 3'd0;
	localparam logic [2:0] FMT_J = 3'd1;
	localparam logic [2:0] FMT_B = 3'd2;
	localparam logic [2:0] FMT_I = 3'd3;
	localparam logic [2:0] FMT_R = 3'd4;
	localparam logic [2:0] FMT_S = 3'd5;

	// Funct3 codes per instruction group.
	localparam logic [2:0] F3_JALR    = 3'd0;
	localparam logic [2:0] F3_BEQ     = 3'd0;
	localparam logic [2:0] F3_BNE     = 3'd1;
	localparam logic [2:0] F3_BLT     = 3'd4;
	localparam logic [2:0] F3_BGE     = 3'd5;
	localparam logic [2:0] F3_BLTU    = 3'd6;
	localparam logic [2:0] F3_BGEU    = 3'd7;
	localparam logic [2:0] F3_LB      = 3'd0;
	localparam logic [2:0] F3_LH      = 3'd1;
	localparam logic [2:0] F3_LW      = 3'd2;
	localparam logic [2:0] F3_LBU     = 3'd4;
	localparam logic [2:0] F3_LHU     = 3'd5;
	localparam logic [2:0] F3_SB      = 3'd0;
	localparam logic [2:0] F3_SH      = 3'd1;
	localparam logic [2:0] F3_SW      = 3'd2;
	localparam logic [2:0] F3_ADD_SUB = 3'd0;
	localparam logic [2:0] F3_SLL     = 3'd1;
	localparam logic [2:0] F3_SLT     = 3'd2;
	localparam logic [2:0] F3_SLTU    = 3'd3;
	localparam logic [2:0] F3_XOR     = 3'd4;
	localparam logic [2:0] F3_SRL_SRA = 3'd5;
	localparam logic [2:0] F3_OR      = 3'd6;
	localparam logic [2:0] F3_AND     = 3'd7;

	// Operation numbers.
	localparam logic [5:0] OP_LUI   = 6'd0;
	localparam logic [5:0] OP_AUIPC = 6'd1;
	localparam logic [5:0] OP_JAL   = 6'd2;
	localparam logic [5:0] OP_BEQ   = 6'd3;
	localparam logic [5:0] OP_BNE   = 6'd4;
	localparam logic [5:0] OP_BLT   = 6'd5;
	localparam logic [5:0] OP_BGE   = 6'd6;
	localparam logic [5:0] OP_BLTU  = 6'd7;
	localparam logic [5:0] OP_BGEU  = 6'd8;
	localparam logic [5:0] OP_JALR  = 6'd9;
	localparam logic [5:0] OP_LB    = 6'd10;
	localparam logic [5:0] OP_LH    = 6'd11;
	localparam logic [5:0] OP_LW    = 6'd12;
	localparam logic [5:0] OP_LBU   = 6'd13;
	localparam logic [5:0] OP_LHU   = 6'd14;
	localparam logic [5:0] OP_ADDI  = 6'd15;
	localparam logic [5:0] OP_SLTI  = 6'd16;
	localparam logic [5:0] OP_SLTIU = 6'd17;
	localparam logic [5:0] OP_XORI  = 6'd18;
	localparam logic [5:0] OP_ORI   = 6'd19;
	localparam logic [5:0] OP_ANDI  = 6'd20;
	localparam logic [5:0] OP_SLLI  = 6'd21;
	localparam logic [5:0] OP_SRLI  = 6'd22;
	localparam logic [5:0] OP_SRAI  = 6'd23;
	localparam logic [5:0] OP_SB    = 6'd24;
	localparam logic [5:0] OP_SH    = 6'd25;
	localparam logic [5:0] OP_SW    = 6'd26;
	localparam logic [5:0] OP_ADD   = 6'd27;
	localparam logic [5:0] OP_SUB   = 6'd28;
	localparam logic [5:0] OP_SLL   = 6'd29;
	localparam logic [5:0] OP_SLT   = 6'd30;
	localparam logic [5:0] OP_SLTU  = 6'd31;
	localparam logic [5:0] OP_XOR   = 6'd32;
	localparam logic [5:0] OP_SRL   = 6'd33;
	localparam logic [5:0] OP_SRA   = 6'd34;
	localparam logic [5:0] OP_OR    = 6'd35;
	localparam logic [5:0] OP_AND   = 6'd36;
	localparam logic [5:0] OP_LAST  = OP_AND;

	// Register index that marks an unused register slot.
	localparam logic signed [5:0] NO_REG = -6'sd1;

	// Width of the packed result payload on the output stream.
	localparam int unsigned RESULT_TDATA_W = 64;

	typedef struct packed {
		logic               illegal;
		logic [2:0]         format_class;
		logic [5:0]         operation;
		logic signed [5:0]  dest_reg;
		logic signed [5:0]  src_reg_a;
		logic signed [5:0]  src_reg_b;
		logic signed [31:0] immediate;
	} rvdec_result_t;

endpackage

FILE: src/rv32i_instruction_decoder.sv
// Top level of the RV32I instruction decoder: input register, decode, result register.
// A beat accepted into the input register is decoded and stored in the result register,
// which drives m_tvalid. Throughput: one instruction per cycle while m_tready is high;
// the decode path is a single pass of opcode and funct3 selection between the input
// register and the result register.
// Reset: arst_n clears both stage valid flags at once; payload registers are not reset.
module rv32i_instruction_decoder (
	input  logic        clk,
	input  logic        arst_n,
	// Slave side: one instruction per beat.
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [31:0] instr_word
	// Master side: one decoded result per beat.
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [rvdec_pkg::RESULT_TDATA_W-1:0] m_tdata,
	// m_tdata fields from the lowest bit up: [2:0] format_class, [8:3] operation,
	// [14:9] dest_reg, [20:15] src_reg_a, [26:21] src_reg_b, [58:27] immediate,
	// [63:59] zero.
	output logic        m_tuser    // [0] illegal
);
	import rvdec_pkg::*;

	// Stage 1 holds the raw instruction; stage 2 holds the decoded result.
	logic          valid_s1;
	logic [31:0]   instr_s1;
	logic          valid_s2;
	rvdec_result_t result_s2;
	rvdec_result_t decoded;

	logic load_s2;
	logic load_s1;

	// The result register takes a new beat when it is empty or being drained.
	// The input register moves on whenever its content can go forward, so a
	// stalled result still leaves room for one more instruction upstream.
	assign load_s2  = !valid_s2 || m_tready;
	assign s_tready = !valid_s1 || load_s2;
	assign load_s1  = s_tvalid && s_tready;

	rvdec_decode u_decode (
		.instr_word (instr_s1),
		.result     (decoded)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (load_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			instr_s1 <= s_tdata;
		end
		if (load_s2 && valid_s1) begin
			result_s2 <= decoded;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tuser  = result_s2.illegal;
	assign m_tdata  = {5'b0, result_s2.immediate, result_s2.src_reg_b, result_s2.src_reg_a,
		result_s2.dest_reg, result_s2.operation, result_s2.format_class};

	// An illegal instruction carries the fixed filler pattern in every field.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> result_s2.format_class == FMT_U &&
		result_s2.operation == OP_LUI && result_s2.dest_reg == NO_REG &&
		result_s2.src_reg_a == NO_REG && result_s2.src_reg_b == NO_REG &&
		result_s2.immediate == 32'sd0)
	else $error("illegal result with non-filler fields");

	// A legal result names one of the base operations only.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> result_s2.operation <= OP_LAST)
	else $error("operation number out of range");

	// Branches and stores have no destination; every other legal format has one.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |->
		((result_s2.dest_reg == NO_REG) ==
		(result_s2.format_class == FMT_B || result_s2.format_class == FMT_S)))
	else $error("destination register does not match the format");

	// A held instruction in stage 1 is not overwritten while the result stalls.
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && valid_s2 && !m_tready |=> valid_s1 && $stable(instr_s1))
	else $error("stage 1 instruction lost during a stall");

endmodule

FILE: src/rvdec_decode.sv
// Combinational field decode of one RV32I instruction word.
module rvdec_decode (
	input  logic [31:0]            instr_word,
	output rvdec_pkg::rvdec_result_t result
);
	import rvdec_pkg::*;

	logic [6:0] opc;
	logic [2:0] f3;
	logic       b30;

	assign opc = instr_word[6:0];
	assign f3  = instr_word[14:12];
	assign b30 = instr_word[30];

	always_comb begin
		logic              bad;
		logic [2:0]        fmt;
		logic [5:0]        op;
		logic signed [5:0] rd;
		logic signed [5:0] rs1;
		logic signed [5:0] rs2;
		logic [31:0]       imm;

		bad = 1'b0;
		fmt = FMT_U;
		op  = OP_LUI;
		rd  = NO_REG;
		rs1 = NO_REG;
		rs2 = NO_REG;
		imm = '0;

		case (opc)
			OPC_LUI, OPC_AUIPC: begin
				fmt = FMT_U;
				op  = (opc == OPC_LUI) ? OP_LUI : OP_AUIPC;
				rd  = {1'b0, instr_word[11:7]};
				imm = {instr_word[31:12], 12'b0};
			end
			OPC_JAL: begin
				fmt = FMT_J;
				op  = OP_JAL;
				rd  = {1'b0, instr_word[11:7]};
				imm = {{11{instr_word[31]}}, instr_word[31], instr_word[19:12],
					instr_word[20], instr_word[30:21], 1'b0};
			end
			OPC_BRANCH: begin
				fmt = FMT_B;
				rs1 = {1'b0, instr_word[19:15]};
				rs2 = {1'b0, instr_word[24:20]};
				imm = {{19{instr_word[31]}}, instr_word[31], instr_word[7],
					instr_word[30:25], instr_word[11:8], 1'b0};
				case (f3)
					F3_BEQ:  op = OP_BEQ;
					F3_BNE:  op = OP_BNE;
					F3_BLT:  op = OP_BLT;
					F3_BGE:  op = OP_BGE;
					F3_BLTU: op = OP_BLTU;
					F3_BGEU: op = OP_BGEU;
					default: bad = 1'b1;
				endcase
			end
			OPC_JALR, OPC_LOAD, OPC_OP_IMM: begin
				fmt = FMT_I;
				rd  = {1'b0, instr_word[11:7]};
				rs1 = {1'b0, instr_word[19:15]};
				imm = {{20{instr_word[31]}}, instr_word[31:20]};
				if (opc == OPC_JALR) begin
					op  = OP_JALR;
					bad = (f3 != F3_JALR);
				end else if (opc == OPC_LOAD) begin
					case (f3)
						F3_LB:   op = OP_LB;
						F3_LH:   op = OP_LH;
						F3_LW:   op = OP_LW;
						F3_LBU:  op = OP_LBU;
						F3_LHU:  op = OP_LHU;
						default: bad = 1'b1;
					endcase
				end else begin
					case (f3)
						F3_ADD_SUB: op = OP_ADDI;
						F3_SLL:     op = OP_SLLI;
						F3_SLT:     op = OP_SLTI;
						F3_SLTU:    op = OP_SLTIU;
						F3_XOR:     op = OP_XORI;
						F3_SRL_SRA: op = b30 ? OP_SRAI : OP_SRLI;
						F3_OR:      op = OP_ORI;
						F3_AND:     op = OP_ANDI;
						default:    bad = 1'b1;
					endcase
					// Shift amounts keep the raw 12-bit field, zero-extended.
					if (f3 == F3_SLL || f3 == F3_SRL_SRA) begin
						imm = {20'b0, instr_word[31:20]};
					end
				end
			end
			OPC_OP: begin
				fmt = FMT_R;
				rd  = {1'b0, instr_word[11:7]};
				rs1 = {1'b0, instr_word[19:15]};
				rs2 = {1'b0, instr_word[24:20]};
				imm = '1;
				case (f3)
					F3_ADD_SUB: op = b30 ? OP_SUB : OP_ADD;
					F3_SLL:     op = OP_SLL;
					F3_SLT:     op = OP_SLT;
					F3_SLTU:    op = OP_SLTU;
					F3_XOR:     op = OP_XOR;
					F3_SRL_SRA: op = b30 ? OP_SRA : OP_SRL;
					F3_OR:      op = OP_OR;
					F3_AND:     op = OP_AND;
					default:    bad = 1'b1;
				endcase
			end
			OPC_STORE: begin
				fmt = FMT_S;
				rs1 = {1'b0, instr_word[19:15]};
				rs2 = {1'b0, instr_word[24:20]};
				imm = {{20{instr_word[31]}}, instr_word[31:25], instr_word[11:7]};
				case (f3)
					F3_SB:   op = OP_SB;
					F3_SH:   op = OP_SH;
					F3_SW:   op = OP_SW;
					default: bad = 1'b1;
				endcase
			end
			default: bad = 1'b1;
		endcase

		if (bad) begin
			result.illegal      = 1'b1;
			result.format_class = FMT_U;
			result.operation    = OP_LUI;
			result.dest_reg     = NO_REG;
			result.src_reg_a    = NO_REG;
			result.src_reg_b    = NO_REG;
			result.immediate    = '0;
		end else begin
			result.illegal      = 1'b0;
			result.format_class = fmt;
			result.operation    = op;
			result.dest_reg     = rd;
			result.src_reg_a    = rs1;
			result.src_reg_b    = rs2;
			result.immediate    = imm;
		end
	end

endmodule

FILE: test/rv32i_instruction_decoder_tb.sv
// Self-checking stream testbench for the RV32I instruction decoder, with its own decode model.
module rv32i_instruction_decoder_tb;

	import rvdec_pkg::*;

	// Major opcodes that the decoder does not support.
	localparam logic [6:0] OPC_MISC_MEM = 7'b0001111;
	localparam logic [6:0] OPC_SYSTEM   = 7'b1110011;

	// An instruction that has been accepted, paired with the decode it must produce.
	typedef struct {
		logic [31:0]   word;
		rvdec_result_t res;
	} pending_decode_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] s_tdata;   // [31:0] instr_word
	logic        m_tvalid;
	logic        m_tready;
	logic [RESULT_TDATA_W-1:0] m_tdata;
	// m_tdata fields from the lowest bit up: [2:0] format_class, [8:3] operation,
	// [14:9] dest_reg, [20:15] src_reg_a, [26:21] src_reg_b, [58:27] immediate, [63:59] zero.
	logic        m_tuser;   // [0] illegal

	pending_decode_t expected_decodes[$];
	int  mismatch_count = 0;
	bit  send_gaps_on = 1'b1;
	bit  sink_stalls_on = 1'b1;
	int  sink_hold_left = 0;
	bit  wide_pattern = 1'b0;

	rv32i_instruction_decoder u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Independent decode of one instruction word into the expected result fields.
	function automatic rvdec_result_t decode_instr(input logic [31:0] w);
		rvdec_result_t r;
		logic [6:0]    opc;
		logic [2:0]    f3;
		logic          legal;
		opc = w[6:0];
		f3 = w[14:12];
		legal = 1'b1;
		r.illegal = 1'b0;
		r.format_class = FMT_U;
		r.operation = OP_LUI;
		r.dest_reg = NO_REG;
		r.src_reg_a = NO_REG;
		r.src_reg_b = NO_REG;
		r.immediate = '0;
		case (opc)
			OPC_LUI, OPC_AUIPC: begin
				r.format_class = FMT_U;
				r.operation = (opc == OPC_LUI) ? OP_LUI : OP_AUIPC;
				r.dest_reg = {1'b0, w[11:7]};
				r.immediate = {w[31:12], 12'h000};
			end
			OPC_JAL: begin
				r.format_class = FMT_J;
				r.operation = OP_JAL;
				r.dest_reg = {1'b0, w[11:7]};
				r.immediate = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
			end
			OPC_BRANCH: begin
				r.format_class = FMT_B;
				case (f3)
					F3_BEQ:  r.operation = OP_BEQ;
					F3_BNE:  r.operation = OP_BNE;
					F3_BLT:  r.operation = OP_BLT;
					F3_BGE:  r.operation = OP_BGE;
					F3_BLTU: r.operation = OP_BLTU;
					F3_BGEU: r.operation = OP_BGEU;
					default: legal = 1'b0;
				endcase
				r.src_reg_a = {1'b0, w[19:15]};
				r.src_reg_b = {1'b0, w[24:20]};
				r.immediate = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
			end
			OPC_JALR, OPC_LOAD, OPC_OP_IMM: begin
				r.format_class = FMT_I;
				r.dest_reg = {1'b0, w[11:7]};
				r.src_reg_a = {1'b0, w[19:15]};
				r.immediate = {{20{w[31]}}, w[31:20]};
				if (opc == OPC_JALR) begin
					if (f3 == F3_JALR)
						r.operation = OP_JALR;
					else
						legal = 1'b0;
				end else if (opc == OPC_LOAD) begin
					case (f3)
						F3_LB:   r.operation = OP_LB;
						F3_LH:   r.operation = OP_LH;
						F3_LW:   r.operation = OP_LW;
						F3_LBU:  r.operation = OP_LBU;
						F3_LHU:  r.operation = OP_LHU;
						default: legal = 1'b0;
					endcase
				end else begin
					case (f3)
						F3_ADD_SUB: r.operation = OP_ADDI;
						F3_SLL:     r.operation = OP_SLLI;
						F3_SLT:     r.operation = OP_SLTI;
						F3_SLTU:    r.operation = OP_SLTIU;
						F3_XOR:     r.operation = OP_XORI;
						F3_SRL_SRA: r.operation = w[30] ? OP_SRAI : OP_SRLI;
						F3_OR:      r.operation = OP_ORI;
						default:    r.operation = OP_ANDI;
					endcase
					// Shift immediates keep the whole 12-bit field, unsigned.
					if (f3 == F3_SLL || f3 == F3_SRL_SRA)
						r.immediate = {20'h00000, w[31:20]};
				end
			end
			OPC_OP: begin
				r.format_class = FMT_R;
				case (f3)
					F3_ADD_SUB: r.operation = w[30] ? OP_SUB : OP_ADD;
					F3_SLL:     r.operation = OP_SLL;
					F3_SLT:     r.operation = OP_SLT;
					F3_SLTU:    r.operation = OP_SLTU;
					F3_XOR:     r.operation = OP_XOR;
					F3_SRL_SRA: r.operation = w[30] ? OP_SRA : OP_SRL;
					F3_OR:      r.operation = OP_OR;
					default:    r.operation = OP_AND;
				endcase
				r.dest_reg = {1'b0, w[11:7]};
				r.src_reg_a = {1'b0, w[19:15]};
				r.src_reg_b = {1'b0, w[24:20]};
				r.immediate = '1;
			end
			OPC_STORE: begin
				r.format_class = FMT_S;
				case (f3)
					F3_SB:   r.operation = OP_SB;
					F3_SH:   r.operation = OP_SH;
					F3_SW:   r.operation = OP_SW;
					default: legal = 1'b0;
				endcase
				r.src_reg_a = {1'b0, w[19:15]};
				r.src_reg_b = {1'b0, w[24:20]};
				r.immediate = {{20{w[31]}}, w[31:25], w[11:7]};
			end
			default: legal = 1'b0;
		endcase
		if (!legal) begin
			r.illegal = 1'b1;
			r.format_class = FMT_U;
			r.operation = OP_LUI;
			r.dest_reg = NO_REG;
			r.src_reg_a = NO_REG;
			r.src_reg_b = NO_REG;
			r.immediate = '0;
		end
		return r;
	endfunction

	task automatic report_mismatch(input string field, input logic [31:0] word,
			input logic [63:0] got, input logic [63:0] want);
		if (mismatch_count < 50)
			$display("MISMATCH %s: instr %h got %h want %h", field, word, got, want);
		mismatch_count++;
	endtask

	// Offers one instruction beat, with an optional random gap before it, and records
	// the expected decode once the beat is accepted. Returns right after the accepting edge.
	task automatic send_instr(input logic [31:0] w);
		pending_decode_t p;
		@(negedge clk);
		if (send_gaps_on && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= w;
		do @(posedge clk); while (s_tready !== 1'b1);
		p.word = w;
		p.res = decode_instr(w);
		expected_decodes.push_back(p);
	endtask

	// Builds a word for one operation. Successive calls swing the free fields between
	// their all-ones and all-zeros extremes; bit 30 is set as given.
	task automatic send_op(input logic [6:0] opc, input logic [2:0] f3, input logic b30);
		logic [31:0] w;
		if (wide_pattern)
			w = {1'b1, b30, 5'h1f, 5'd31, 5'd0, f3, 5'd31, opc};
		else
			w = {1'b0, b30, 5'h00, 5'd0, 5'd31, f3, 5'd0, opc};
		wide_pattern = ~wide_pattern;
		send_instr(w);
	endtask

	// Mostly well-formed words: a supported major opcode under random upper bits, which
	// also hits the unsupported funct3 slots; the rest is fully random noise.
	function automatic logic [31:0] random_instr();
		logic [31:0] w;
		w = $urandom();
		if ($urandom_range(0, 99) < 85) begin
			case ($urandom_range(0, 8))
				0: w[6:0] = OPC_LUI;
				1: w[6:0] = OPC_AUIPC;
				2: w[6:0] = OPC_JAL;
				3: w[6:0] = OPC_BRANCH;
				4: w[6:0] = OPC_JALR;
				5: w[6:0] = OPC_LOAD;
				6: w[6:0] = OPC_OP_IMM;
				7: w[6:0] = OPC_OP;
				default: w[6:0] = OPC_STORE;
			endcase
		end
		return w;
	endfunction

	task automatic test_each_operation();
		send_op(OPC_LUI, 3'd7, 1'b1);
		send_op(OPC_AUIPC, 3'd0, 1'b0);
		send_op(OPC_JAL, 3'd7, 1'b1);
		send_op(OPC_BRANCH, F3_BEQ, 1'b0);
		send_op(OPC_BRANCH, F3_BNE, 1'b1);
		send_op(OPC_BRANCH, F3_BLT, 1'b0);
		send_op(OPC_BRANCH, F3_BGE, 1'b1);
		send_op(OPC_BRANCH, F3_BLTU, 1'b0);
		send_op(OPC_BRANCH, F3_BGEU, 1'b1);
		send_op(OPC_JALR, F3_JALR, 1'b0);
		send_op(OPC_LOAD, F3_LB, 1'b1);
		send_op(OPC_LOAD, F3_LH, 1'b0);
		send_op(OPC_LOAD, F3_LW, 1'b1);
		send_op(OPC_LOAD, F3_LBU, 1'b0);
		send_op(OPC_LOAD, F3_LHU, 1'b1);
		send_op(OPC_OP_IMM, F3_ADD_SUB, 1'b0);
		send_op(OPC_OP_IMM, F3_SLT, 1'b1);
		send_op(OPC_OP_IMM, F3_SLTU, 1'b0);
		send_op(OPC_OP_IMM, F3_XOR, 1'b1);
		send_op(OPC_OP_IMM, F3_OR, 1'b0);
		send_op(OPC_OP_IMM, F3_AND, 1'b1);
		send_op(OPC_OP_IMM, F3_SLL, 1'b0);
		send_op(OPC_OP_IMM, F3_SRL_SRA, 1'b0);
		send_op(OPC_OP_IMM, F3_SRL_SRA, 1'b1);
		send_op(OPC_STORE, F3_SB, 1'b0);
		send_op(OPC_STORE, F3_SH, 1'b1);
		send_op(OPC_STORE, F3_SW, 1'b0);
		send_op(OPC_OP, F3_ADD_SUB, 1'b0);
		send_op(OPC_OP, F3_ADD_SUB, 1'b1);
		send_op(OPC_OP, F3_SLL, 1'b1);
		send_op(OPC_OP, F3_SLT, 1'b0);
		send_op(OPC_OP, F3_SLTU, 1'b1);
		send_op(OPC_OP, F3_XOR, 1'b0);
		send_op(OPC_OP, F3_SRL_SRA, 1'b0);
		send_op(OPC_OP, F3_SRL_SRA, 1'b1);
		send_op(OPC_OP, F3_OR, 1'b1);
		send_op(OPC_OP, F3_AND, 1'b0);
	endtask

	task automatic test_special_cases();
		// Unknown major opcodes, including the all-zeros and all-ones words.
		send_instr(32'h0000_0000);
		send_instr(32'hFFFF_FFFF);
		// Fence and system instructions are not supported.
		send_instr({4'h0, 4'hF, 4'hF, 5'd0, 3'd0, 5'd0, OPC_MISC_MEM});
		send_instr({12'h000, 5'd0, 3'd0, 5'd0, OPC_SYSTEM});
		send_instr({12'h001, 5'd0, 3'd0, 5'd0, OPC_SYSTEM});
		// Unused funct3 slots in the branch, jump-register, load and store groups.
		send_instr({7'h55, 5'd3, 5'd4, 3'd2, 5'd5, OPC_BRANCH});
		send_instr({7'h2a, 5'd6, 5'd7, 3'd3, 5'd8, OPC_BRANCH});
		send_instr({12'hABC, 5'd9, 3'd1, 5'd10, OPC_JALR});
		send_instr({12'h123, 5'd11, 3'd3, 5'd12, OPC_LOAD});
		send_instr({12'hFED, 5'd13, 3'd6, 5'd14, OPC_LOAD});
		send_instr({12'h800, 5'd15, 3'd7, 5'd16, OPC_LOAD});
		send_instr({7'h7f, 5'd17, 5'd18, 3'd3, 5'd19, OPC_STORE});
		send_instr({7'h00, 5'd20, 5'd21, 3'd7, 5'd22, OPC_STORE});
		// Most negative and most positive immediates, plus an all-ones store immediate.
		send_instr({1'b1, 19'h00000, 5'd0, OPC_JAL});
		send_instr({1'b0, 19'h7FFFF, 5'd31, OPC_JAL});
		send_instr({1'b1, 24'h000000, OPC_BRANCH});
		send_instr({1'b0, 6'h3f, 5'd31, 5'd31, F3_BNE, 4'hf, 1'b1, OPC_BRANCH});
		send_instr({12'h800, 5'd1, F3_ADD_SUB, 5'd2, OPC_OP_IMM});
		send_instr({12'h7FF, 5'd3, F3_ADD_SUB, 5'd4, OPC_OP_IMM});
		send_instr({7'h7f, 5'd0, 5'd0, F3_SW, 5'h1f, OPC_STORE});
		// Funct7 bits other than bit 30 are ignored; shifts keep them in the immediate.
		send_instr({7'h7f, 5'd31, 5'd0, F3_SLL, 5'd1, OPC_OP_IMM});
		send_instr({7'h7f, 5'd31, 5'd0, F3_SRL_SRA, 5'd1, OPC_OP_IMM});
		send_instr({7'h5f, 5'd2, 5'd3, F3_ADD_SUB, 5'd4, OPC_OP});
		send_instr({7'h5f, 5'd5, 5'd6, F3_SRL_SRA, 5'd7, OPC_OP});
	endtask

	// Random instruction stream; idling is switched on and off per block of beats
	// so that quiet stretches sit between the bursty ones.
	task automatic test_random_stream(input int count);
		for (int i = 0; i < count; i++) begin
			if (i % 100 == 0) begin
				send_gaps_on = ($urandom_range(0, 2) != 0);
				sink_stalls_on = ($urandom_range(0, 2) != 0);
			end
			send_instr(random_instr());
		end
		send_gaps_on = 1'b1;
		sink_stalls_on = 1'b1;
	endtask

	// The sink refuses results for a long stretch while the source keeps offering,
	// so the pipeline fills and the decoder must hold off its input.
	task automatic test_output_backpressure(input int count);
		send_gaps_on = 1'b0;
		send_instr(random_instr());
		sink_hold_left = 300;
		for (int i = 1; i < count; i++)
			send_instr(random_instr());
		send_gaps_on = 1'b1;
	endtask

	// Back-to-back beats with the sink always ready, at full rate.
	task automatic test_full_rate(input int count);
		send_gaps_on = 1'b0;
		sink_stalls_on = 1'b0;
		for (int i = 0; i < count; i++)
			send_instr(random_instr());
	endtask

	// Result sink: tready changes at the falling edge. A long hold requested by a test
	// takes priority; otherwise random stall bursts are drawn while enabled.
	initial begin
		int stall_left;
		stall_left = 0;
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (sink_hold_left > 0) begin
				m_tready <= 1'b0;
				sink_hold_left--;
			end else if (stall_left > 0) begin
				m_tready <= 1'b0;
				stall_left--;
			end else if (sink_stalls_on && $urandom_range(0, 5) == 0) begin
				m_tready <= 1'b0;
				stall_left = $urandom_range(1, 18) - 1;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Every accepted result beat is checked against the oldest pending decode.
	always @(posedge clk) begin : result_check
		pending_decode_t p;
		if (arst_n && m_tvalid === 1'b1 && m_tready === 1'b1) begin
			if (expected_decodes.size() == 0) begin
				report_mismatch("unexpected result", 32'h0, m_tdata, 64'h0);
			end else begin
				p = expected_decodes.pop_front();
				if (m_tuser !== p.res.illegal)
					report_mismatch("illegal", p.word, m_tuser, p.res.illegal);
				if (m_tdata[2:0] !== p.res.format_class)
					report_mismatch("format_class", p.word, m_tdata[2:0], p.res.format_class);
				if (m_tdata[8:3] !== p.res.operation)
					report_mismatch("operation", p.word, m_tdata[8:3], p.res.operation);
				if (m_tdata[14:9] !== p.res.dest_reg)
					report_mismatch("dest_reg", p.word, m_tdata[14:9], p.res.dest_reg);
				if (m_tdata[20:15] !== p.res.src_reg_a)
					report_mismatch("src_reg_a", p.word, m_tdata[20:15], p.res.src_reg_a);
				if (m_tdata[26:21] !== p.res.src_reg_b)
					report_mismatch("src_reg_b", p.word, m_tdata[26:21], p.res.src_reg_b);
				if (m_tdata[58:27] !== p.res.immediate)
					report_mismatch("immediate", p.word, m_tdata[58:27], p.res.immediate);
				if (m_tdata[63:59] !== 5'b00000)
					report_mismatch("tdata padding", p.word, m_tdata[63:59], 64'h0);
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_each_operation();
		test_special_cases();
		test_random_stream(1150);
		test_output_backpressure(150);
		test_full_rate(200);

		@(negedge clk);
		s_tvalid <= 1'b0;
		while (expected_decodes.size() != 0)
			@(posedge clk);
		// Let a stray extra beat show up if the pipeline produces one.
		repeat (10) @(posedge clk);

		if (mismatch_count == 0 && expected_decodes.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

	initial begin
		#1000000;
		$display("Verification failed");
		$finish;
	end

endmodule
